>>> hw/rtl/toaq_pkg.sv
// types and codes shared by the timed output action queue
package toaq_pkg;

  // width of the signed hold counter
  localparam int unsigned HoldCntW = 18;
  // packed widths of the stream payloads
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_TICK = 1'b1
  } state_e;

  // one queued action as held in the action memory
  typedef struct packed {
    logic [15:0] hold_time;
    logic        out_level;
    logic [5:0]  out_pin;
  } entry_t;

  // one result request
  typedef struct packed {
    logic [CountOutW-1:0] queue_count;
    logic                 dropped;
    logic                 all_off;
    logic                 drive_level;
    logic [5:0]           drive_pin;
    logic                 drive_valid;
  } result_t;

endpackage

>>> hw/rtl/timed_output_action_queue_top.sv
// timed output action queue: fifo of timed pin writes held in one memory
//
// Actions are kept in a circular buffer memory of QUEUE_DEPTH entries with a
// head and a tail pointer, so a pop never moves the stored entries. Every
// accepted request gives exactly one result request. Enqueue, clear and the
// unused command are answered straight from the idle state; a tick first goes
// through ST_TICK, since the head entry comes out of the synchronous action
// memory in the cycle after the tick is accepted, and the next request is
// accepted once that tick has produced its result. The result waits in an
// output register and a new request is taken in the cycle that register is
// drained. No clearing pass follows reset: only entries between head and tail are ever used.
module timed_output_action_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // seconds_passed [15:0], out_pin [21:16], out_level [22], hold_time [38:23]
  input  logic [toaq_pkg::InDataW-1:0]  s_axis_tdata,
  // command [1:0]
  input  logic [toaq_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // drive_valid [0], drive_pin [6:1], drive_level [7], all_off [8],
  // dropped [9], queue_count [14:10]
  output logic [toaq_pkg::OutDataW-1:0] m_axis_tdata
);
  import toaq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_q;

  state_e state_q, state_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic signed [HoldCntW-1:0] hc_q, hc_d;
  logic out_valid_q, out_valid_d;
  result_t out_q, out_d;

  cmd_e   in_cmd;
  logic [15:0] in_secs;
  entry_t in_entry;
  logic   in_fire, out_free, wr_en;
  logic [31:0] count_ext;

  assign in_cmd             = cmd_e'(s_axis_tuser);
  assign in_secs            = s_axis_tdata[15:0];
  assign in_entry.out_pin   = s_axis_tdata[21:16];
  assign in_entry.out_level = s_axis_tdata[22];
  assign in_entry.hold_time = s_axis_tdata[38:23];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    hc_d        = hc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    wr_en       = 1'b0;
    count_ext   = 32'(count_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d = '0;
          unique case (in_cmd)
            CMD_TICK: begin
              // count down only while positive; the pop decision follows the read
              if (!hc_q[HoldCntW-1] && (hc_q != '0)) begin
                hc_d = hc_q - $signed({2'b00, in_secs});
              end
              state_d = ST_TICK;
            end
            CMD_ENQUEUE: begin
              if (count_q == FullCnt) begin
                out_d.dropped = 1'b1;
              end else begin
                wr_en   = 1'b1;
                tail_d  = ptr_inc(tail_q);
                count_d = count_q + CntW'(1);
              end
            end
            CMD_CLEAR: begin
              head_d        = '0;
              tail_d        = '0;
              count_d       = '0;
              hc_d          = '0;
              out_d.all_off = 1'b1;
            end
            default: ;
          endcase
          if (in_cmd != CMD_TICK) begin
            count_ext         = 32'(count_d);
            out_d.queue_count = count_ext[CountOutW-1:0];
            out_valid_d       = 1'b1;
          end
        end
      end
      ST_TICK: begin
        out_d = '0;
        if ((hc_q[HoldCntW-1] || (hc_q == '0)) && (count_q != '0)) begin
          out_d.drive_valid = 1'b1;
          out_d.drive_pin   = rd_q.out_pin;
          out_d.drive_level = rd_q.out_level;
          if (count_q == CntW'(1)) begin
            // last action gone: everything back to its cleared state
            head_d        = '0;
            tail_d        = '0;
            count_d       = '0;
            hc_d          = '0;
            out_d.all_off = 1'b1;
          end else begin
            head_d  = ptr_inc(head_q);
            count_d = count_q - CntW'(1);
            hc_d    = $signed({2'b00, rd_q.hold_time});
          end
        end
        count_ext         = 32'(count_d);
        out_d.queue_count = count_ext[CountOutW-1:0];
        out_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      hc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      hc_q        <= hc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // action memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= in_entry;
    end
    rd_q <= mem_q[head_q];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (hc_q == '0 && head_q == tail_q))
    else $error("empty queue with live counter or pointers apart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> (count_q == FullCnt))
    else $error("drop reported with room in the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (!s_axis_tready && !out_valid_q))
    else $error("request taken or result pending during tick");

endmodule

>>> verif/tb_timed_output_action_queue_top.sv
// testbench for the timed output action queue: stream driver, result monitor and predictor
`timescale 1ns / 1ps

module tb_timed_output_action_queue_top;
  import toaq_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] secs;
    logic [5:0]  pin;
    logic        level;
    logic [15:0] hold;
  } req_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // seconds_passed, out_pin, out_level, hold_time, zero pad
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // command
  logic [CmdW-1:0]     s_axis_tuser = CMD_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // drive_valid, drive_pin, drive_level, all_off, dropped, queue_count, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  timed_output_action_queue_top #(
    .QUEUE_DEPTH (Depth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state
  entry_t  action_fifo [Depth];
  int      queued_cnt = 0;
  int      hold_left = 0;

  req_t    req_backlog [$];
  result_t due_results [$];
  req_t    cur_req = '0;
  int      n_pushed = 0;
  int      n_taken = 0;
  int      src_gap = 0;
  int      sink_gap = 0;
  bit      calm = 1'b0;
  int      err_cnt = 0;
  int      n_drive = 0;
  int      n_drop = 0;
  int      n_off = 0;
  int      n_full = 0;

  function automatic result_t apply_command(req_t r);
    result_t res;
    int      k;
    res = '0;
    case (r.cmd)
      CMD_TICK: begin
        if (hold_left > 0) hold_left -= int'(r.secs);
        if (hold_left <= 0 && queued_cnt > 0) begin
          res.drive_valid = 1'b1;
          res.drive_pin   = action_fifo[0].out_pin;
          res.drive_level = action_fifo[0].out_level;
          hold_left = int'(action_fifo[0].hold_time);
          for (k = 0; k < Depth - 1; k++) action_fifo[k] = action_fifo[k+1];
          action_fifo[Depth-1] = '0;
          queued_cnt--;
          // last action gone: its hold time is thrown away
          if (queued_cnt == 0) begin
            hold_left   = 0;
            res.all_off = 1'b1;
          end
        end
      end
      CMD_ENQUEUE: begin
        if (queued_cnt >= Depth) begin
          res.dropped = 1'b1;
        end else begin
          action_fifo[queued_cnt] = '{hold_time: r.hold, out_level: r.level, out_pin: r.pin};
          queued_cnt++;
        end
      end
      CMD_CLEAR: begin
        for (k = 0; k < Depth; k++) action_fifo[k] = '0;
        queued_cnt  = 0;
        hold_left   = 0;
        res.all_off = 1'b1;
      end
      default: ;
    endcase
    res.queue_count = queued_cnt[CountOutW-1:0];
    return res;
  endfunction

  // sender: one request per handshake, random bursts of idling
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(apply_command(cur_req));
        n_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!calm && src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && req_backlog.size() != 0 && $urandom_range(9) == 0) begin
          src_gap = $urandom_range(12);
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          cur_req       <= req_backlog[0];
          s_axis_tdata  <= {1'b0, req_backlog[0].hold, req_backlog[0].level,
                            req_backlog[0].pin, req_backlog[0].secs};
          s_axis_tuser  <= req_backlog[0].cmd;
          s_axis_tvalid <= 1'b1;
          void'(req_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready <= rst_ni;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(9) == 0) begin
      sink_gap = $urandom_range(12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string what, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, what, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[OutDataW-2:0]);
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("drive_valid", want.drive_valid, got.drive_valid);
        check_field("drive_pin", want.drive_pin, got.drive_pin);
        check_field("drive_level", want.drive_level, got.drive_level);
        check_field("all_off", want.all_off, got.all_off);
        check_field("dropped", want.dropped, got.dropped);
        check_field("queue_count", want.queue_count, got.queue_count);
        check_field("pad bit", 0, m_axis_tdata[OutDataW-1]);
        n_drive += want.drive_valid;
        n_drop  += want.dropped;
        n_off   += want.all_off;
        if (want.queue_count == Depth) n_full++;
      end
    end
  end

  task automatic push_req(cmd_e c, int unsigned s, int unsigned p, int unsigned l,
                          int unsigned h);
    req_t r;
    r.cmd   = c;
    r.secs  = s[15:0];
    r.pin   = p[5:0];
    r.level = l[0];
    r.hold  = h[15:0];
    req_backlog.push_back(r);
    n_pushed++;
  endtask

  // mostly short times so that actions pop often, now and then the full range
  function automatic int unsigned pick_seconds();
    int unsigned roll;
    roll = $urandom_range(19);
    if (roll < 15) return $urandom_range(12);
    if (roll == 15) return 16'hffff;
    if (roll == 16) return 0;
    return $urandom_range(16'hffff);
  endfunction

  task automatic push_random(int unsigned enq_pct);
    int unsigned roll;
    cmd_e        c;
    roll = $urandom_range(99);
    if (roll < enq_pct) c = CMD_ENQUEUE;
    else if (roll < 95) c = CMD_TICK;
    else if (roll < 98) c = CMD_CLEAR;
    else c = CMD_NONE;
    push_req(c, pick_seconds(), $urandom_range(63), $urandom_range(1), pick_seconds());
  endtask

  task automatic wait_drained();
    while (n_taken != n_pushed || due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned enq_pct;
    for (int unsigned k = 0; k < n; k++) begin
      // vary the fill bias so the queue swings between empty and full
      if (k % 50 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 75;
        endcase
      end
      push_random(enq_pct);
    end
  endtask

  initial begin
    #4_000_000;
    $display("tb_timed_output_action_queue_top: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tick with nothing queued, then extreme field values
    push_req(CMD_TICK, 16'hffff, 63, 1, 16'hffff);
    push_req(CMD_ENQUEUE, 0, 63, 1, 16'hffff);
    push_req(CMD_ENQUEUE, 16'hffff, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 0, 0);
    // counter runs from full hold to zero and the last action clears all
    push_req(CMD_TICK, 16'hffff, 0, 0, 0);
    push_req(CMD_CLEAR, 0, 0, 0, 0);
    for (int unsigned k = 0; k < Depth; k++) push_req(CMD_ENQUEUE, 0, k * 4 + 3, k, k);
    // queue full: refused
    push_req(CMD_ENQUEUE, 0, 42, 1, 7);
    push_req(CMD_TICK, 0, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 0, 0);
    push_req(CMD_CLEAR, 16'hffff, 63, 1, 16'hffff);
    push_req(CMD_NONE, 16'hffff, 63, 1, 16'hffff);

    // sender holds off until every result is back
    wait_drained();
    random_phase(700);
    wait_drained();
    random_phase(600);
    wait_drained();
    calm = 1'b1;
    random_phase(150);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("%0d requests checked: %0d actions driven, %0d refused when full, %0d all-off",
             n_taken, n_drive, n_drop, n_off);
    $display("queue seen full %0d times, idling on both sides except in the last stretch",
             n_full);
    if (err_cnt == 0) begin
      $display("tb_timed_output_action_queue_top: done, clean");
    end else begin
      $display("tb_timed_output_action_queue_top: done, errors");
    end
    $finish;
  end

endmodule
